@@ rtl/msg_pkg.sv @@
// ----------------------------------------------------------------------------
// msg_pkg: shared types and constants of the motion safety gate
// register map, result codes, configuration and queue transfer types
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package msg_pkg;

	localparam int AGE_W    = 24;
	localparam int LIM_W    = 15;
	localparam int DIST_W   = 16;
	localparam int COV_W    = 16;
	localparam int CONF_W   = 17;
	localparam int ADDR_W   = 5;
	localparam int DATA_W   = 32;

	localparam logic [AGE_W-1:0]  AGE_TOP  = '1;
	localparam logic [COV_W-1:0]  COV_BAD  = '1;
	localparam logic [DIST_W-1:0] DIST_NONE = '1;

	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
	localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

	typedef enum logic [1:0] {
		ACT_PASS = 2'd0,
		ACT_SLOW = 2'd1,
		ACT_STOP = 2'd2
	} action_t;

	typedef enum logic [2:0] {
		RSN_NONE     = 3'd0,
		RSN_LOCAL    = 3'd1,
		RSN_DEPTH    = 3'd2,
		RSN_CAMERA   = 3'd3,
		RSN_OBSTACLE = 3'd4,
		RSN_CONF     = 3'd5,
		RSN_PATH     = 3'd6,
		RSN_COMMAND  = 3'd7
	} reason_t;

	typedef enum logic [2:0] {
		REG_CAM_STALE  = 3'd0,
		REG_DEP_STALE  = 3'd1,
		REG_EMERG_DIST = 3'd2,
		REG_CONF_FLOOR = 3'd3,
		REG_TOP_SPEED  = 3'd4,
		REG_SLOW_SPEED = 3'd5,
		REG_COV_LIMIT  = 3'd6,
		REG_FUTURE_TOL = 3'd7
	} reg_idx_t;

	typedef struct packed {
		logic [AGE_W-1:0]  cam_stale;
		logic [AGE_W-1:0]  dep_stale;
		logic [DIST_W-1:0] emerg_dist;
		logic [CONF_W-1:0] conf_floor;
		logic [LIM_W-1:0]  top_speed;
		logic [LIM_W-1:0]  slow_speed;
		logic [COV_W-1:0]  cov_limit;
		logic [AGE_W-1:0]  future_tol;
	} cfg_t;

	localparam cfg_t CFG_RESET = '{
		cam_stale:  24'd200000,
		dep_stale:  24'd200000,
		emerg_dist: 16'd500,
		conf_floor: 17'd32768,
		top_speed:  15'd1000,
		slow_speed: 15'd300,
		cov_limit:  16'd1000,
		future_tol: 24'd100000
	};

	// classification handed from front to back
	typedef struct packed {
		reason_t           reason;
		logic              slow;
		logic [LIM_W-1:0]  limit;
		logic [AGE_W-1:0]  cam_age;
		logic [AGE_W-1:0]  dep_age;
	} meta_t;

	typedef struct packed {
		logic                   full;
		logic                   empty;
		logic [QUEUE_CNT_W-1:0] count;
	} q_stat_t;

endpackage

`default_nettype wire

@@ rtl/msg_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// msg_cfg_regs: configuration register file
// apb-style write and read access to the eight threshold registers
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module msg_cfg_regs (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       psel,
	input  wire logic                       penable,
	input  wire logic                       pwrite,
	input  wire logic [msg_pkg::ADDR_W-1:0] paddr,
	input  wire logic [msg_pkg::DATA_W-1:0] pwdata,
	output logic      [msg_pkg::DATA_W-1:0] prdata,
	output logic                            pready,
	output msg_pkg::cfg_t                   cfg
);
	import msg_pkg::*;

	cfg_t     cfg_q;
	reg_idx_t reg_idx;
	logic     wr_en;

	assign pready  = 1'b1;
	assign reg_idx = reg_idx_t'(paddr[ADDR_W-1:2]);
	assign wr_en   = psel & penable & pwrite & pready;
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_CAM_STALE:  cfg_q.cam_stale  <= pwdata[AGE_W-1:0];
				REG_DEP_STALE:  cfg_q.dep_stale  <= pwdata[AGE_W-1:0];
				REG_EMERG_DIST: cfg_q.emerg_dist <= pwdata[DIST_W-1:0];
				REG_CONF_FLOOR: cfg_q.conf_floor <= pwdata[CONF_W-1:0];
				REG_TOP_SPEED:  cfg_q.top_speed  <= pwdata[LIM_W-1:0];
				REG_SLOW_SPEED: cfg_q.slow_speed <= pwdata[LIM_W-1:0];
				REG_COV_LIMIT:  cfg_q.cov_limit  <= pwdata[COV_W-1:0];
				REG_FUTURE_TOL: cfg_q.future_tol <= pwdata[AGE_W-1:0];
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_CAM_STALE:  prdata = DATA_W'(cfg_q.cam_stale);
			REG_DEP_STALE:  prdata = DATA_W'(cfg_q.dep_stale);
			REG_EMERG_DIST: prdata = DATA_W'(cfg_q.emerg_dist);
			REG_CONF_FLOOR: prdata = DATA_W'(cfg_q.conf_floor);
			REG_TOP_SPEED:  prdata = DATA_W'(cfg_q.top_speed);
			REG_SLOW_SPEED: prdata = DATA_W'(cfg_q.slow_speed);
			REG_COV_LIMIT:  prdata = DATA_W'(cfg_q.cov_limit);
			REG_FUTURE_TOL: prdata = DATA_W'(cfg_q.future_tol);
		endcase
	end

endmodule

`default_nettype wire

@@ rtl/msg_front.sv @@
// ----------------------------------------------------------------------------
// msg_front: command intake and check chain
// works out sensor ages and classifies each command into stop, slow or pass
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module msg_front #(
	parameter int TIME_BITS  = 48,
	parameter int SPEED_BITS = 16
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       accept,
	input  wire logic [TIME_BITS-1:0]       current_time,
	input  wire logic [TIME_BITS-1:0]       camera_stamp,
	input  wire logic [TIME_BITS-1:0]       depth_stamp,
	input  wire logic                       pose_ok,
	input  wire logic [msg_pkg::COV_W-1:0]  pose_covariance,
	input  wire logic [msg_pkg::DIST_W-1:0] obstacle_distance,
	input  wire logic                       path_ok,
	input  wire logic [SPEED_BITS-1:0]      command_linear,
	input  wire logic [SPEED_BITS-1:0]      command_angular,
	input  wire logic                       command_ok,
	input  wire logic [msg_pkg::CONF_W-1:0] confidence,
	input  wire logic                       confidence_ok,
	input  wire msg_pkg::cfg_t              cfg,
	output logic                            push,
	output msg_pkg::meta_t                  push_meta,
	output logic      [SPEED_BITS-1:0]      push_lin,
	output logic      [SPEED_BITS-1:0]      push_ang
);
	import msg_pkg::*;

	localparam logic [TIME_BITS-1:0] AGE_TOP_T = TIME_BITS'(AGE_TOP);

	typedef struct packed {
		logic             over;
		logic [AGE_W-1:0] age;
	} age_t;

	// stage 1: raw differences and registered side fields
	logic                  valid_s1;
	logic [TIME_BITS:0]    cam_fwd_s1, dep_fwd_s1;
	logic [TIME_BITS-1:0]  cam_ahead_s1, dep_ahead_s1;
	logic                  cam_zero_s1, dep_zero_s1;
	logic                  pose_ok_s1, path_ok_s1, cmd_ok_s1, conf_ok_s1;
	logic [COV_W-1:0]      cov_s1;
	logic [DIST_W-1:0]     dist_s1;
	logic [CONF_W-1:0]     conf_s1;
	logic [SPEED_BITS-1:0] lin_s1, ang_s1;

	age_t    cam_res, dep_res;
	reason_t reason;
	logic    slow;

	function automatic age_t age_of(
		input logic                 zero,
		input logic [TIME_BITS:0]   fwd,
		input logic [TIME_BITS-1:0] ahead,
		input logic [AGE_W-1:0]     tol
	);
		age_t r;
		r.over = 1'b0;
		r.age  = '0;
		if (zero) begin
			r.over = 1'b1;
			r.age  = AGE_TOP;
		end else if (fwd[TIME_BITS]) begin
			// stamp lies ahead of now
			if (ahead > TIME_BITS'(tol)) begin
				r.over = 1'b1;
				r.age  = AGE_TOP;
			end
		end else if (fwd[TIME_BITS-1:0] > AGE_TOP_T) begin
			r.over = 1'b1;
			r.age  = AGE_TOP;
		end else begin
			r.age = fwd[AGE_W-1:0];
		end
		return r;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cam_fwd_s1   <= {1'b0, current_time} - {1'b0, camera_stamp};
			dep_fwd_s1   <= {1'b0, current_time} - {1'b0, depth_stamp};
			cam_ahead_s1 <= camera_stamp - current_time;
			dep_ahead_s1 <= depth_stamp - current_time;
			cam_zero_s1  <= (camera_stamp == '0);
			dep_zero_s1  <= (depth_stamp == '0);
			pose_ok_s1   <= pose_ok;
			cov_s1       <= pose_covariance;
			dist_s1      <= obstacle_distance;
			path_ok_s1   <= path_ok;
			lin_s1       <= command_linear;
			ang_s1       <= command_angular;
			cmd_ok_s1    <= command_ok;
			conf_s1      <= confidence;
			conf_ok_s1   <= confidence_ok;
		end
	end

	assign cam_res = age_of(cam_zero_s1, cam_fwd_s1, cam_ahead_s1, cfg.future_tol);
	assign dep_res = age_of(dep_zero_s1, dep_fwd_s1, dep_ahead_s1, cfg.future_tol);

	// first failing check wins
	always_comb begin
		if (!pose_ok_s1 || cov_s1 == COV_BAD || cov_s1 > cfg.cov_limit) begin
			reason = RSN_LOCAL;
		end else if (dep_res.over || dep_res.age > cfg.dep_stale) begin
			reason = RSN_DEPTH;
		end else if (cam_res.over || cam_res.age > cfg.cam_stale) begin
			reason = RSN_CAMERA;
		end else if (dist_s1 != DIST_NONE && dist_s1 < cfg.emerg_dist) begin
			reason = RSN_OBSTACLE;
		end else if (!path_ok_s1) begin
			reason = RSN_PATH;
		end else if (!cmd_ok_s1) begin
			reason = RSN_COMMAND;
		end else begin
			reason = RSN_NONE;
		end
	end

	assign slow = !conf_ok_s1 || (conf_s1 < cfg.conf_floor);

	assign push              = valid_s1;
	assign push_meta.reason  = reason;
	assign push_meta.slow    = slow;
	assign push_meta.limit   = slow ? cfg.slow_speed : cfg.top_speed;
	assign push_meta.cam_age = cam_res.age;
	assign push_meta.dep_age = dep_res.age;
	assign push_lin          = lin_s1;
	assign push_ang          = ang_s1;

endmodule

`default_nettype wire

@@ rtl/msg_queue.sv @@
// ----------------------------------------------------------------------------
// msg_queue: short transfer queue between front and back
// register-based fifo with first-word read-through
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module msg_queue #(
	parameter int WIDTH = 100
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire logic [WIDTH-1:0] wr_data,
	input  wire logic             pop,
	output logic      [WIDTH-1:0] rd_data,
	output msg_pkg::q_stat_t      stat
);
	import msg_pkg::*;

	logic [WIDTH-1:0]       entry_q [QUEUE_DEPTH];
	logic [QUEUE_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [QUEUE_CNT_W-1:0] count_q;
	logic                   do_push, do_pop;

	assign stat.count = count_q;
	assign stat.empty = (count_q == '0);
	assign stat.full  = (count_q == QUEUE_CNT_W'(QUEUE_DEPTH));
	assign do_push    = push && !stat.full;
	assign do_pop     = pop && !stat.empty;
	assign rd_data    = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

`default_nettype wire

@@ rtl/msg_back.sv @@
// ----------------------------------------------------------------------------
// msg_back: speed ceiling and angular rescale
// multiplier stage then a one-bit-per-stage restoring divider pipeline
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module msg_back #(
	parameter int SPEED_BITS = 16
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        in_valid,
	input  wire msg_pkg::meta_t              in_meta,
	input  wire logic [SPEED_BITS-1:0]       in_lin,
	input  wire logic [SPEED_BITS-1:0]       in_ang,
	output logic                             done,
	output logic      [1:0]                  action,
	output logic      [2:0]                  reason,
	output logic      [msg_pkg::LIM_W-1:0]   speed_limit,
	output logic      [SPEED_BITS-1:0]       linear_out,
	output logic      [SPEED_BITS-1:0]       angular_out,
	output logic                             stopped,
	output logic      [msg_pkg::AGE_W-1:0]   camera_age,
	output logic      [msg_pkg::AGE_W-1:0]   depth_frame_age
);
	import msg_pkg::*;

	localparam int SB    = SPEED_BITS;
	localparam int PW    = SB + LIM_W;
	localparam int REM_W = (LIM_W > SB) ? LIM_W : SB;
	localparam int TRW   = REM_W + 1;
	localparam int XW    = (SB > LIM_W + 1) ? SB : LIM_W + 1;

	// entry 0 is the multiplier stage, entries 1..SB the divider stages
	logic             vld_s  [SB+1];
	meta_t            meta_s [SB+1];
	logic [SB-1:0]    lin_s  [SB+1];
	logic [SB-1:0]    ang_s  [SB+1];
	logic [SB-1:0]    spd_s  [SB+1];
	logic             ndiv_s [SB+1];
	logic [REM_W-1:0] rem_s  [SB+1];
	logic [SB-1:0]    low_s  [SB+1];
	logic [SB-1:0]    quo_s  [SB+1];

	logic [SB-1:0] lin_mag, ang_mag;
	logic [PW-1:0] prod;
	logic          need_div;

	assign lin_mag  = in_lin[SB-1] ? SB'(0) - in_lin : in_lin;
	assign ang_mag  = in_ang[SB-1] ? SB'(0) - in_ang : in_ang;
	assign prod     = PW'(ang_mag) * PW'(in_meta.limit);
	assign need_div = XW'(lin_mag) > XW'(in_meta.limit);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else begin
			vld_s[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		meta_s[0] <= in_meta;
		lin_s[0]  <= in_lin;
		ang_s[0]  <= in_ang;
		spd_s[0]  <= lin_mag;
		ndiv_s[0] <= need_div;
		rem_s[0]  <= REM_W'(prod[PW-1:SB]);
		low_s[0]  <= prod[SB-1:0];
		quo_s[0]  <= '0;
	end

	for (genvar k = 1; k <= SB; k++) begin : g_div
		logic [TRW-1:0] trial, diff;
		logic           ge;

		assign trial = {rem_s[k-1], low_s[k-1][SB-1]};
		assign ge    = trial >= TRW'(spd_s[k-1]);
		assign diff  = trial - TRW'(spd_s[k-1]);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else begin
				vld_s[k] <= vld_s[k-1];
			end
		end

		always_ff @(posedge clk) begin
			meta_s[k] <= meta_s[k-1];
			lin_s[k]  <= lin_s[k-1];
			ang_s[k]  <= ang_s[k-1];
			spd_s[k]  <= spd_s[k-1];
			ndiv_s[k] <= ndiv_s[k-1];
			rem_s[k]  <= ge ? diff[REM_W-1:0] : trial[REM_W-1:0];
			low_s[k]  <= low_s[k-1] << 1;
			quo_s[k]  <= {quo_s[k-1][SB-2:0], ge};
		end
	end

	// result assembly
	meta_t         fin_meta;
	logic [XW-1:0] lim_x, lim_neg_x;
	logic [SB-1:0] lin_res, ang_res;
	logic          halt;

	assign fin_meta  = meta_s[SB];
	assign halt      = (fin_meta.reason != RSN_NONE);
	assign lim_x     = XW'(fin_meta.limit);
	assign lim_neg_x = XW'(0) - lim_x;

	always_comb begin
		if (ndiv_s[SB]) begin
			lin_res = lin_s[SB][SB-1] ? lim_neg_x[SB-1:0] : lim_x[SB-1:0];
			ang_res = ang_s[SB][SB-1] ? SB'(0) - quo_s[SB] : quo_s[SB];
		end else begin
			lin_res = lin_s[SB];
			ang_res = ang_s[SB];
		end
	end

	logic            done_q, stopped_q;
	action_t         action_q;
	reason_t         reason_q;
	logic [LIM_W-1:0] limit_q;
	logic [SB-1:0]   lin_q, ang_q;
	logic [AGE_W-1:0] cam_age_q, dep_age_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= vld_s[SB];
		end
	end

	always_ff @(posedge clk) begin
		cam_age_q <= fin_meta.cam_age;
		dep_age_q <= fin_meta.dep_age;
		if (halt) begin
			action_q  <= ACT_STOP;
			reason_q  <= fin_meta.reason;
			limit_q   <= '0;
			lin_q     <= '0;
			ang_q     <= '0;
			stopped_q <= 1'b1;
		end else begin
			action_q  <= fin_meta.slow ? ACT_SLOW : ACT_PASS;
			reason_q  <= fin_meta.slow ? RSN_CONF : RSN_NONE;
			limit_q   <= fin_meta.limit;
			lin_q     <= lin_res;
			ang_q     <= ang_res;
			stopped_q <= 1'b0;
		end
	end

	assign done            = done_q;
	assign action          = action_q;
	assign reason          = reason_q;
	assign speed_limit     = limit_q;
	assign linear_out      = lin_q;
	assign angular_out     = ang_q;
	assign stopped         = stopped_q;
	assign camera_age      = cam_age_q;
	assign depth_frame_age = dep_age_q;

endmodule

`default_nettype wire

@@ rtl/motion_safety_gate_top.sv @@
// ----------------------------------------------------------------------------
// motion_safety_gate_top: velocity command safety gate
// checks sensor freshness, localisation, obstacles, path and command, then
// caps the forwarded speed and rescales the turn rate
// ----------------------------------------------------------------------------
// A command is taken at any clock edge with start high and busy low, and one
// result follows for every command, in order, on the result ports for a single
// cycle marked by done; the receiver cannot stall it. The block takes one
// command per clock while busy is low, and each command passes through one
// front stage for the time differences, one queue slot, one multiplier
// stage, a restoring divider of SPEED_BITS one-bit stages for the angular
// rescale, and the output register. Busy comes from the four-entry queue
// between the check chain and the speed stage and stays low in normal use,
// since the back end drains one entry every cycle. Thresholds sit behind
// the apb-style port and should be written only while no command is in
// flight.
`timescale 1ns / 1ps
`default_nettype none

module motion_safety_gate_top #(
	parameter int TIME_BITS  = 48,
	parameter int SPEED_BITS = 16
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	// apb-style configuration port
	input  wire logic                       psel,
	input  wire logic                       penable,
	input  wire logic                       pwrite,
	input  wire logic [msg_pkg::ADDR_W-1:0] paddr,
	input  wire logic [msg_pkg::DATA_W-1:0] pwdata,
	output logic      [msg_pkg::DATA_W-1:0] prdata,
	output logic                            pready,
	// command transfer
	input  wire logic                       start,
	output logic                            busy,
	input  wire logic [TIME_BITS-1:0]       current_time,
	input  wire logic [TIME_BITS-1:0]       camera_stamp,
	input  wire logic [TIME_BITS-1:0]       depth_stamp,
	input  wire logic                       pose_ok,
	input  wire logic [msg_pkg::COV_W-1:0]  pose_covariance,
	input  wire logic [msg_pkg::DIST_W-1:0] obstacle_distance,
	input  wire logic                       path_ok,
	input  wire logic [SPEED_BITS-1:0]      command_linear,
	input  wire logic [SPEED_BITS-1:0]      command_angular,
	input  wire logic                       command_ok,
	input  wire logic [msg_pkg::CONF_W-1:0] confidence,
	input  wire logic                       confidence_ok,
	// result transfer
	output logic                            done,
	output logic      [1:0]                 action,
	output logic      [2:0]                 reason,
	output logic      [msg_pkg::LIM_W-1:0]  speed_limit,
	output logic      [SPEED_BITS-1:0]      linear_out,
	output logic      [SPEED_BITS-1:0]      angular_out,
	output logic                            stopped,
	output logic      [msg_pkg::AGE_W-1:0]  camera_age,
	output logic      [msg_pkg::AGE_W-1:0]  depth_frame_age
);
	import msg_pkg::*;

	localparam int Q_W     = $bits(meta_t) + 2 * SPEED_BITS;
	localparam int LATENCY = SPEED_BITS + 4;

	cfg_t    cfg;
	logic    accept;

	// front to queue
	logic                  f_push;
	meta_t                 f_meta;
	logic [SPEED_BITS-1:0] f_lin, f_ang;

	// queue to back
	logic [Q_W-1:0]        q_rd_data;
	q_stat_t               q_stat;
	logic                  q_pop;
	meta_t                 hd_meta;
	logic [SPEED_BITS-1:0] hd_lin, hd_ang;

	// hold off commands once the queue could not absorb those already in the
	// front stage plus a new one
	assign busy   = ({1'b0, q_stat.count} + (QUEUE_CNT_W + 1)'(f_push))
	                >= (QUEUE_CNT_W + 1)'(QUEUE_DEPTH);
	assign accept = start && !busy;

	msg_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	msg_front #(
		.TIME_BITS  (TIME_BITS),
		.SPEED_BITS (SPEED_BITS)
	) u_front (
		.clk               (clk),
		.arst_n            (arst_n),
		.accept            (accept),
		.current_time      (current_time),
		.camera_stamp      (camera_stamp),
		.depth_stamp       (depth_stamp),
		.pose_ok           (pose_ok),
		.pose_covariance   (pose_covariance),
		.obstacle_distance (obstacle_distance),
		.path_ok           (path_ok),
		.command_linear    (command_linear),
		.command_angular   (command_angular),
		.command_ok        (command_ok),
		.confidence        (confidence),
		.confidence_ok     (confidence_ok),
		.cfg               (cfg),
		.push              (f_push),
		.push_meta         (f_meta),
		.push_lin          (f_lin),
		.push_ang          (f_ang)
	);

	msg_queue #(
		.WIDTH (Q_W)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (f_push),
		.wr_data ({f_meta, f_lin, f_ang}),
		.pop     (q_pop),
		.rd_data (q_rd_data),
		.stat    (q_stat)
	);

	// the back end never stalls, so the head moves on every cycle it is there
	assign q_pop = !q_stat.empty;
	assign {hd_meta, hd_lin, hd_ang} = q_rd_data;

	msg_back #(
		.SPEED_BITS (SPEED_BITS)
	) u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (q_pop),
		.in_meta         (hd_meta),
		.in_lin          (hd_lin),
		.in_ang          (hd_ang),
		.done            (done),
		.action          (action),
		.reason          (reason),
		.speed_limit     (speed_limit),
		.linear_out      (linear_out),
		.angular_out     (angular_out),
		.stopped         (stopped),
		.camera_age      (camera_age),
		.depth_frame_age (depth_frame_age)
	);

	// a transfer into the queue is never lost to a full queue
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		f_push |-> !q_stat.full)
		else $error("front transfer into full queue");

	// every accepted command yields its result after the fixed latency
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> ##LATENCY done)
		else $error("result missing after fixed latency");

	// no result without a command accepted the same latency earlier
	a_no_ghost: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(accept, LATENCY))
		else $error("result without matching command");

	// a stop result carries a stop reason and zeroed motion
	a_stop_fields: assert property (@(posedge clk) disable iff (!arst_n)
		done && stopped |-> (reason != RSN_NONE) && (reason != RSN_CONF)
		&& (linear_out == '0) && (angular_out == '0))
		else $error("stop result with motion or wrong reason");

endmodule

`default_nettype wire

@@ tb/tb.sv @@
// ----------------------------------------------------------------------------
// tb: self-checking bench for the motion safety gate
// drives command transfers and apb-style threshold writes, predicts every
// verdict from its own copy of the thresholds and checks each result in order
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

	import msg_pkg::*;

	localparam int TIME_W           = 48;
	localparam int SPD_W            = 16;
	localparam int LATENCY          = SPD_W + 4;
	localparam int CYCLE_LIMIT      = 200000;
	localparam int RANDOM_PER_PHASE = 140;
	localparam int LAST_PHASE       = 6;

	// one command as it crosses the start/busy transfer
	typedef struct packed {
		logic [TIME_W-1:0]       current_time;
		logic [TIME_W-1:0]       camera_stamp;
		logic [TIME_W-1:0]       depth_stamp;
		logic                    pose_ok;
		logic [COV_W-1:0]        pose_covariance;
		logic [DIST_W-1:0]       obstacle_distance;
		logic                    path_ok;
		logic signed [SPD_W-1:0] command_linear;
		logic signed [SPD_W-1:0] command_angular;
		logic                    command_ok;
		logic [CONF_W-1:0]       confidence;
		logic                    confidence_ok;
	} command_t;

	// one verdict as it leaves on the done strobe
	typedef struct packed {
		logic [1:0]              action;
		logic [2:0]              reason;
		logic [LIM_W-1:0]        speed_limit;
		logic signed [SPD_W-1:0] linear_out;
		logic signed [SPD_W-1:0] angular_out;
		logic                    stopped;
		logic [AGE_W-1:0]        camera_age;
		logic [AGE_W-1:0]        depth_frame_age;
	} verdict_t;

	// shape of the random traffic
	typedef enum int {
		MIX_CLEAN,
		MIX_BROKEN,
		MIX_NOISE
	} traffic_t;

	// check that a broken command is made to fail
	typedef enum int {
		FLT_POSE,
		FLT_DEPTH,
		FLT_CAMERA,
		FLT_OBSTACLE,
		FLT_PATH,
		FLT_COMMAND
	} fault_t;

	// verdict predictor and in-order store of expected verdicts
	class gate_scoreboard;
		cfg_t        cfg;
		verdict_t    expected_q[$];
		int unsigned failures;

		function new();
			cfg = CFG_RESET;
			failures = 0;
		endfunction

		function void set_register(reg_idx_t idx, logic [31:0] val);
			case (idx)
				REG_CAM_STALE:  cfg.cam_stale  = val[AGE_W-1:0];
				REG_DEP_STALE:  cfg.dep_stale  = val[AGE_W-1:0];
				REG_EMERG_DIST: cfg.emerg_dist = val[DIST_W-1:0];
				REG_CONF_FLOOR: cfg.conf_floor = val[CONF_W-1:0];
				REG_TOP_SPEED:  cfg.top_speed  = val[LIM_W-1:0];
				REG_SLOW_SPEED: cfg.slow_speed = val[LIM_W-1:0];
				REG_COV_LIMIT:  cfg.cov_limit  = val[COV_W-1:0];
				REG_FUTURE_TOL: cfg.future_tol = val[AGE_W-1:0];
				default: ;
			endcase
		endfunction

		function int pending();
			return expected_q.size();
		endfunction

		function string show(verdict_t v);
			return $sformatf("act=%0d rsn=%0d lim=%0d lin=%0d ang=%0d stop=%0d cam=%0d dep=%0d",
				v.action, v.reason, v.speed_limit, $signed(v.linear_out),
				$signed(v.angular_out), v.stopped, v.camera_age, v.depth_frame_age);
		endfunction

		// saturated frame age, over set when the frame counts as lost
		function logic [AGE_W-1:0] frame_age(logic [TIME_W-1:0] now,
				logic [TIME_W-1:0] stamp, output bit over);
			logic [TIME_W-1:0] d;
			over = 1'b0;
			if (stamp == '0) begin
				over = 1'b1;
				return AGE_TOP;
			end
			if (stamp > now) begin
				d = stamp - now;
				if (d > cfg.future_tol) begin
					over = 1'b1;
					return AGE_TOP;
				end
				return '0;
			end
			d = now - stamp;
			if (d > AGE_TOP) begin
				over = 1'b1;
				return AGE_TOP;
			end
			return d[AGE_W-1:0];
		endfunction

		function void note_command(command_t c);
			verdict_t v;
			reason_t  why;
			bit       cam_over;
			bit       dep_over;
			bit       slow;
			int       ceil_i;
			int       lin_i;
			int       ang_i;
			int       mag_i;
			longint   amag;
			v.camera_age      = frame_age(c.current_time, c.camera_stamp, cam_over);
			v.depth_frame_age = frame_age(c.current_time, c.depth_stamp, dep_over);
			if (!c.pose_ok || c.pose_covariance == COV_BAD
					|| c.pose_covariance > cfg.cov_limit)
				why = RSN_LOCAL;
			else if (dep_over || v.depth_frame_age > cfg.dep_stale)
				why = RSN_DEPTH;
			else if (cam_over || v.camera_age > cfg.cam_stale)
				why = RSN_CAMERA;
			else if (c.obstacle_distance != DIST_NONE
					&& c.obstacle_distance < cfg.emerg_dist)
				why = RSN_OBSTACLE;
			else if (!c.path_ok)
				why = RSN_PATH;
			else if (!c.command_ok)
				why = RSN_COMMAND;
			else
				why = RSN_NONE;
			if (why != RSN_NONE) begin
				v.action      = ACT_STOP;
				v.reason      = why;
				v.speed_limit = '0;
				v.linear_out  = '0;
				v.angular_out = '0;
				v.stopped     = 1'b1;
			end else begin
				slow   = !c.confidence_ok || c.confidence < cfg.conf_floor;
				ceil_i = slow ? cfg.slow_speed : cfg.top_speed;
				lin_i  = $signed(c.command_linear);
				ang_i  = $signed(c.command_angular);
				mag_i  = (lin_i < 0) ? -lin_i : lin_i;
				if (mag_i > ceil_i) begin
					lin_i = (lin_i < 0) ? -ceil_i : ceil_i;
					amag  = (ang_i < 0) ? -ang_i : ang_i;
					amag  = (amag * ceil_i) / mag_i;
					ang_i = (ang_i < 0) ? -int'(amag) : int'(amag);
				end
				v.action      = slow ? ACT_SLOW : ACT_PASS;
				v.reason      = slow ? RSN_CONF : RSN_NONE;
				v.speed_limit = ceil_i[LIM_W-1:0];
				v.linear_out  = lin_i[SPD_W-1:0];
				v.angular_out = ang_i[SPD_W-1:0];
				v.stopped     = 1'b0;
			end
			expected_q.push_back(v);
		endfunction

		function void check_verdict(verdict_t got);
			verdict_t want;
			if (expected_q.size() == 0) begin
				failures++;
				if (failures <= 10)
					$display("unexpected result: %s", show(got));
				return;
			end
			want = expected_q.pop_front();
			if (got.action !== want.action || got.reason !== want.reason
					|| got.speed_limit !== want.speed_limit
					|| got.linear_out !== want.linear_out
					|| got.angular_out !== want.angular_out
					|| got.stopped !== want.stopped
					|| got.camera_age !== want.camera_age
					|| got.depth_frame_age !== want.depth_frame_age) begin
				failures++;
				if (failures <= 10) begin
					$display("mismatch expected: %s", show(want));
					$display("mismatch actual:   %s", show(got));
				end
			end
		endfunction
	endclass

	logic                    clk = 1'b0;
	logic                    arst_n;
	logic                    psel;
	logic                    penable;
	logic                    pwrite;
	logic [ADDR_W-1:0]       paddr;
	logic [DATA_W-1:0]       pwdata;
	logic [DATA_W-1:0]       prdata;
	logic                    pready;
	logic                    start;
	logic                    busy;
	logic [TIME_W-1:0]       current_time;
	logic [TIME_W-1:0]       camera_stamp;
	logic [TIME_W-1:0]       depth_stamp;
	logic                    pose_ok;
	logic [COV_W-1:0]        pose_covariance;
	logic [DIST_W-1:0]       obstacle_distance;
	logic                    path_ok;
	logic [SPD_W-1:0]        command_linear;
	logic [SPD_W-1:0]        command_angular;
	logic                    command_ok;
	logic [CONF_W-1:0]       confidence;
	logic                    confidence_ok;
	logic                    done;
	logic [1:0]              action;
	logic [2:0]              reason;
	logic [LIM_W-1:0]        speed_limit;
	logic [SPD_W-1:0]        linear_out;
	logic [SPD_W-1:0]        angular_out;
	logic                    stopped;
	logic [AGE_W-1:0]        camera_age;
	logic [AGE_W-1:0]        depth_frame_age;

	int unsigned             cycle_count;
	gate_scoreboard          sb = new();

	motion_safety_gate_top #(
		.TIME_BITS  (TIME_W),
		.SPEED_BITS (SPD_W)
	) u_dut (.*);

	// 20 ns clock
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// note every command transfer, sampled on the edge that takes it
	always @(posedge clk) begin : command_mon
		command_t seen;
		if (arst_n && start && !busy) begin
			seen.current_time      = current_time;
			seen.camera_stamp      = camera_stamp;
			seen.depth_stamp       = depth_stamp;
			seen.pose_ok           = pose_ok;
			seen.pose_covariance   = pose_covariance;
			seen.obstacle_distance = obstacle_distance;
			seen.path_ok           = path_ok;
			seen.command_linear    = command_linear;
			seen.command_angular   = command_angular;
			seen.command_ok        = command_ok;
			seen.confidence        = confidence;
			seen.confidence_ok     = confidence_ok;
			sb.note_command(seen);
		end
	end

	// results cannot be held off, so each done cycle is a transfer
	always @(posedge clk) begin : result_mon
		verdict_t got;
		if (arst_n && done) begin
			got.action          = action;
			got.reason          = reason;
			got.speed_limit     = speed_limit;
			got.linear_out      = linear_out;
			got.angular_out     = angular_out;
			got.stopped         = stopped;
			got.camera_age      = camera_age;
			got.depth_frame_age = depth_frame_age;
			sb.check_verdict(got);
		end
	end

	// run limit, far beyond the slowest correct run
	initial begin : watchdog
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("TB_ERROR");
		$finish;
	end

	function automatic logic [TIME_W-1:0] rand48();
		return TIME_W'({$urandom, $urandom});
	endfunction

	// stamp giving a fresh frame, or one that must be judged stale
	function automatic logic [TIME_W-1:0] stamp_for(logic [TIME_W-1:0] now,
			logic [AGE_W-1:0] lim, logic [AGE_W-1:0] tol, bit fresh);
		logic [TIME_W-1:0] s;
		if (fresh) begin
			case ($urandom_range(0, 5))
				0:       s = now - lim;
				1:       s = now + $urandom_range(0, tol);
				2:       s = now;
				default: s = now - $urandom_range(0, lim);
			endcase
			if (s == '0)
				s = 1;
		end else begin
			case ($urandom_range(0, 4))
				0:       s = '0;
				1:       s = now - lim - 1;
				2:       s = now + tol + 1 + $urandom_range(0, 1000);
				3:       s = now - 48'h100_0000 - $urandom_range(0, 65535);
				default: s = now - 48'hFF_FFFF;
			endcase
		end
		return s;
	endfunction

	// random command shaped against the thresholds now in force
	function automatic command_t make_command(traffic_t mix);
		command_t c;
		cfg_t     k;
		fault_t   f;
		int       lin_pick;
		k = sb.cfg;
		c.current_time = rand48();
		if (mix == MIX_NOISE) begin
			c.camera_stamp      = ($urandom_range(0, 7) == 0) ? '0 : rand48();
			c.depth_stamp       = ($urandom_range(0, 7) == 0) ? '0 : rand48();
			c.pose_ok           = $urandom;
			c.pose_covariance   = $urandom;
			c.obstacle_distance = $urandom;
			c.path_ok           = $urandom;
			c.command_linear    = $urandom;
			c.command_angular   = $urandom;
			c.command_ok        = $urandom;
			c.confidence        = $urandom;
			c.confidence_ok     = $urandom;
			return c;
		end
		// keep stamps clear of the bottom of the time range
		if (c.current_time < 48'h400_0000)
			c.current_time += 48'h400_0000;
		c.camera_stamp = stamp_for(c.current_time, k.cam_stale, k.future_tol, 1'b1);
		c.depth_stamp  = stamp_for(c.current_time, k.dep_stale, k.future_tol, 1'b1);
		c.pose_ok = 1'b1;
		if ($urandom_range(0, 4) == 0)
			c.pose_covariance = k.cov_limit;
		else
			c.pose_covariance = $urandom_range(0, k.cov_limit);
		if (c.pose_covariance == COV_BAD)
			c.pose_covariance = COV_BAD - 1;
		case ($urandom_range(0, 3))
			0:       c.obstacle_distance = DIST_NONE;
			1:       c.obstacle_distance = k.emerg_dist;
			default: c.obstacle_distance = $urandom_range(k.emerg_dist, 65535);
		endcase
		c.path_ok    = 1'b1;
		c.command_ok = 1'b1;
		case ($urandom_range(0, 4))
			0:       c.confidence = k.conf_floor;
			1:       c.confidence = k.conf_floor - 1;
			2:       c.confidence = 17'd65536;
			default: c.confidence = $urandom_range(0, 65536);
		endcase
		c.confidence_ok = ($urandom_range(0, 7) != 0);
		case ($urandom_range(0, 5))
			0: begin
				// just around one of the ceilings
				lin_pick = $urandom_range(0, 1) ? int'(k.top_speed) : int'(k.slow_speed);
				lin_pick = lin_pick + int'($urandom_range(0, 2)) - 1;
				if ($urandom_range(0, 1))
					lin_pick = -lin_pick;
				c.command_linear = SPD_W'(lin_pick);
			end
			1:       c.command_linear = $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
			default: c.command_linear = $urandom;
		endcase
		if ($urandom_range(0, 7) == 0)
			c.command_angular = $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
		else
			c.command_angular = $urandom;
		if (mix == MIX_BROKEN) begin
			// one or two failing checks, so the priority order is seen too
			repeat ($urandom_range(1, 2)) begin
				f = fault_t'($urandom_range(0, int'(FLT_COMMAND)));
				case (f)
					FLT_POSE: begin
						case ($urandom_range(0, 2))
							0: c.pose_ok = 1'b0;
							1: c.pose_covariance = COV_BAD;
							default: begin
								if (k.cov_limit < 16'hFFFE)
									c.pose_covariance =
										$urandom_range(int'(k.cov_limit) + 1, 65534);
								else
									c.pose_covariance = COV_BAD;
							end
						endcase
					end
					FLT_DEPTH:
						c.depth_stamp = stamp_for(c.current_time, k.dep_stale,
							k.future_tol, 1'b0);
					FLT_CAMERA:
						c.camera_stamp = stamp_for(c.current_time, k.cam_stale,
							k.future_tol, 1'b0);
					FLT_OBSTACLE: begin
						if (k.emerg_dist > 0)
							c.obstacle_distance = $urandom_range(0, int'(k.emerg_dist) - 1);
						else
							c.obstacle_distance = '0;
					end
					FLT_PATH:    c.path_ok = 1'b0;
					FLT_COMMAND: c.command_ok = 1'b0;
					default: ;
				endcase
			end
		end
		return c;
	endfunction

	// present one command and hold it until the transfer happens
	task automatic issue(command_t c);
		start             <= 1'b1;
		current_time      <= c.current_time;
		camera_stamp      <= c.camera_stamp;
		depth_stamp       <= c.depth_stamp;
		pose_ok           <= c.pose_ok;
		pose_covariance   <= c.pose_covariance;
		obstacle_distance <= c.obstacle_distance;
		path_ok           <= c.path_ok;
		command_linear    <= c.command_linear;
		command_angular   <= c.command_angular;
		command_ok        <= c.command_ok;
		confidence        <= c.confidence;
		confidence_ok     <= c.confidence_ok;
		@(posedge clk);
		while (busy)
			@(posedge clk);
	endtask

	// write every threshold back to back, setup then access each time
	task automatic load_thresholds(cfg_t want);
		logic [31:0] val;
		for (int i = 0; i <= int'(REG_FUTURE_TOL); i++) begin
			case (reg_idx_t'(i))
				REG_CAM_STALE:  val = 32'(want.cam_stale);
				REG_DEP_STALE:  val = 32'(want.dep_stale);
				REG_EMERG_DIST: val = 32'(want.emerg_dist);
				REG_CONF_FLOOR: val = 32'(want.conf_floor);
				REG_TOP_SPEED:  val = 32'(want.top_speed);
				REG_SLOW_SPEED: val = 32'(want.slow_speed);
				REG_COV_LIMIT:  val = 32'(want.cov_limit);
				default:        val = 32'(want.future_tol);
			endcase
			psel    <= 1'b1;
			penable <= 1'b0;
			pwrite  <= 1'b1;
			paddr   <= ADDR_W'(4 * i);
			pwdata  <= val;
			@(posedge clk);
			penable <= 1'b1;
			do
				@(posedge clk);
			while (!pready);
			sb.set_register(reg_idx_t'(i), val);
		end
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	// random traffic; with gaps on, gaps fall in alternate stretches of 35 commands
	task automatic run_traffic(int count, bit with_gaps);
		command_t c;
		traffic_t mix;
		int       r;
		for (int i = 0; i < count; i++) begin
			r = $urandom_range(0, 19);
			if (r < 15)
				mix = MIX_CLEAN;
			else if (r < 18)
				mix = MIX_BROKEN;
			else
				mix = MIX_NOISE;
			c = make_command(mix);
			if (with_gaps && ((i / 35) % 2 == 0) && $urandom_range(0, 2) == 0) begin
				start <= 1'b0;
				repeat ($urandom_range(1, 7))
					@(posedge clk);
			end
			issue(c);
		end
	endtask

	// wait until every expected verdict has come back
	task automatic drain();
		do
			@(posedge clk);
		while (sb.pending() != 0);
	endtask

	initial begin : stimulus
		command_t base;
		command_t c;
		cfg_t     want;
		arst_n            <= 1'b0;
		psel              <= 1'b0;
		penable           <= 1'b0;
		pwrite            <= 1'b0;
		paddr             <= '0;
		pwdata            <= '0;
		start             <= 1'b0;
		current_time      <= '0;
		camera_stamp      <= '0;
		depth_stamp       <= '0;
		pose_ok           <= 1'b0;
		pose_covariance   <= '0;
		obstacle_distance <= '0;
		path_ok           <= 1'b0;
		command_linear    <= '0;
		command_angular   <= '0;
		command_ok        <= 1'b0;
		confidence        <= '0;
		confidence_ok     <= 1'b0;
		repeat (10)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed commands against the reset thresholds
		base.current_time      = 48'h0123_4567_89AB;
		base.camera_stamp      = base.current_time - 1000;
		base.depth_stamp       = base.current_time - 2000;
		base.pose_ok           = 1'b1;
		base.pose_covariance   = 16'd10;
		base.obstacle_distance = DIST_NONE;
		base.path_ok           = 1'b1;
		base.command_linear    = 16'sd500;
		base.command_angular   = -16'sd200;
		base.command_ok        = 1'b1;
		base.confidence        = 17'd50000;
		base.confidence_ok     = 1'b1;
		issue(base);
		// linear and angular at their extremes, cut to the ceiling
		c = base; c.command_linear = 16'h7FFF; c.command_angular = 16'h7FFF; issue(c);
		c = base; c.command_linear = 16'h8000; c.command_angular = 16'h8000; issue(c);
		c = base; c.command_linear = 16'h8000; c.command_angular = 16'h7FFF;
		c.confidence_ok = 1'b0; issue(c);
		c = base; c.command_linear = '0; c.command_angular = 16'h8000; issue(c);
		// confidence below, at and above the floor, and above one
		c = base; c.confidence = '0; issue(c);
		c = base; c.confidence = 17'd32768; c.command_linear = 16'sd1000;
		c.command_angular = 16'sd1; issue(c);
		c = base; c.confidence = 17'd65536; c.command_linear = 16'sd1001;
		c.command_angular = 16'sd7; issue(c);
		c = base; c.confidence = 17'h1FFFF; issue(c);
		// localisation
		c = base; c.pose_ok = 1'b0; issue(c);
		c = base; c.pose_covariance = COV_BAD; issue(c);
		c = base; c.pose_covariance = 16'd1001; issue(c);
		c = base; c.pose_covariance = 16'd1000; issue(c);
		// depth never arrived, just stale, just fresh
		c = base; c.depth_stamp = '0; issue(c);
		c = base; c.depth_stamp = base.current_time - 200001; issue(c);
		c = base; c.depth_stamp = base.current_time - 200000; issue(c);
		// camera never arrived, ahead within and beyond the tolerance
		c = base; c.camera_stamp = '0; issue(c);
		c = base; c.camera_stamp = base.current_time + 100000; issue(c);
		c = base; c.camera_stamp = base.current_time + 100001; issue(c);
		// age past the 24-bit range at the very top of time
		c = base; c.current_time = '1; c.camera_stamp = c.current_time - 5;
		c.depth_stamp = 48'd1; issue(c);
		// obstacle just inside, at the limit, and touching
		c = base; c.obstacle_distance = 16'd499; issue(c);
		c = base; c.obstacle_distance = 16'd500; issue(c);
		c = base; c.obstacle_distance = '0; issue(c);
		// path, command, and several failures at once
		c = base; c.path_ok = 1'b0; issue(c);
		c = base; c.command_ok = 1'b0; issue(c);
		c = base; c.pose_ok = 1'b0; c.path_ok = 1'b0; c.command_ok = 1'b0;
		c.depth_stamp = '0; issue(c);
		start <= 1'b0;
		drain();

		for (int phase = 1; phase <= LAST_PHASE; phase++) begin
			want = sb.cfg;
			case (phase)
				2: begin
					// lowest values of every range
					want.cam_stale  = 24'd1;
					want.dep_stale  = 24'd1;
					want.emerg_dist = 16'd1;
					want.conf_floor = 17'd0;
					want.top_speed  = 15'd1;
					want.slow_speed = 15'd1;
					want.cov_limit  = 16'd1;
					want.future_tol = 24'd1;
				end
				3: begin
					// highest values of every range
					want.cam_stale  = 24'hFF_FFFF;
					want.dep_stale  = 24'hFF_FFFF;
					want.emerg_dist = 16'd65534;
					want.conf_floor = 17'd65536;
					want.top_speed  = 15'd32767;
					want.slow_speed = 15'd32767;
					want.cov_limit  = 16'd65534;
					want.future_tol = 24'hFF_FFFF;
				end
				4: begin
					// all zero, below every range
					want = '0;
				end
				5: begin
					// slow ceiling above the top one, wide thresholds
					want.cam_stale  = $urandom_range(1, 24'hFF_FFFF);
					want.dep_stale  = $urandom_range(1, 24'hFF_FFFF);
					want.emerg_dist = $urandom;
					want.conf_floor = $urandom;
					want.top_speed  = $urandom_range(1, 16000);
					want.slow_speed = $urandom_range(int'(want.top_speed) + 1, 32767);
					want.cov_limit  = $urandom;
					want.future_tol = $urandom_range(0, 24'hFF_FFFF);
				end
				default: begin
					// ordinary operating point
					want.cam_stale  = $urandom_range(1000, 400000);
					want.dep_stale  = $urandom_range(1000, 400000);
					want.emerg_dist = $urandom_range(1, 3000);
					want.conf_floor = $urandom_range(0, 65536);
					want.top_speed  = $urandom_range(1, 32767);
					want.slow_speed = $urandom_range(1, want.top_speed);
					want.cov_limit  = $urandom_range(1, 65534);
					want.future_tol = $urandom_range(1, 300000);
				end
			endcase
			load_thresholds(want);
			// no idling in the last part of the run
			run_traffic(RANDOM_PER_PHASE, phase != LAST_PHASE);
			start <= 1'b0;
			drain();
		end

		// let any stray result show up before the verdict
		repeat (LATENCY + 8)
			@(posedge clk);
		if (sb.failures == 0 && sb.pending() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

@@ filelist.f @@
rtl/msg_pkg.sv
rtl/msg_cfg_regs.sv
rtl/msg_front.sv
rtl/msg_queue.sv
rtl/msg_back.sv
rtl/motion_safety_gate_top.sv
tb/tb.sv
